FILE: rtl/core/mlmt_pkg.sv
`timescale 1ns / 1ps

package mlmt_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int NAME_BYTES  = 8;
    localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_ENTRIES - 1);

    // operation codes
    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_UNREGISTER = 2'd1;
    localparam logic [1:0] OP_SAMPLE     = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_LIMITS = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_EMPTY_SLOT = 3'd4;

    // sample actions
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_WARN  = 2'd1;
    localparam logic [1:0] ACT_KILL  = 2'd2;
    localparam logic [1:0] ACT_STALE = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [21:0] process_id;
        logic [63:0] container_tag;
        logic [47:0] soft_limit;
        logic [47:0] hard_limit;
        logic [3:0]  slot_index;
        logic [47:0] resident_bytes;
        logic        task_exists;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_used;
        logic [1:0]  action;
        logic [21:0] entry_pid;
        logic [47:0] limit_crossed;
    } t_rsp;

    typedef struct packed {
        logic [21:0] pid;
        logic [63:0] tag;
        logic [47:0] soft_limit;
        logic [47:0] hard_limit;
        logic        warned;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        t_entry            data;
    } t_ram_wr;

    // cut to NAME_BYTES bytes and clear everything from the first zero byte on
    function automatic logic [63:0] tag_form(input logic [63:0] raw);
        logic [63:0] kept;
        logic        live;
        kept = '0;
        live = 1'b1;
        for (int b = 0; b < NAME_BYTES; b++) begin
            if (raw[8*b +: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                kept[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return kept;
    endfunction

endpackage

FILE: rtl/core/mlmt_if.sv
`timescale 1ns / 1ps

interface mlmt_req_if;
    import mlmt_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mlmt_rsp_if;
    import mlmt_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/mlmt_entry_ram.sv
`timescale 1ns / 1ps

module mlmt_entry_ram (
    input  logic                        i_clk,
    input  mlmt_pkg::t_ram_wr           i_wr,
    input  logic [mlmt_pkg::SLOT_W-1:0] i_raddr,
    output mlmt_pkg::t_entry            o_rdata
);
    import mlmt_pkg::*;

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/mlmt_seq.sv
`timescale 1ns / 1ps

module mlmt_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mlmt_req_if.sink                    i_req,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output mlmt_pkg::t_rsp              o_res,
    output mlmt_pkg::t_ram_wr           o_ram_wr,
    output logic [mlmt_pkg::SLOT_W-1:0] o_ram_raddr,
    input  mlmt_pkg::t_entry            i_ram_rdata
);
    import mlmt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_REG     = 6'b000010,
        S_UNREG   = 6'b000100,
        S_SAMP_RD = 6'b001000,
        S_SAMP_EV = 6'b010000,
        S_RESP    = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    t_req                   r_req, n_req;
    logic [SLOT_W-1:0]      r_scan, n_scan;
    logic                   r_pend, n_pend;
    logic [SLOT_W-1:0]      r_pend_idx, n_pend_idx;
    logic [MAX_ENTRIES-1:0] r_valid, n_valid;
    t_rsp                   r_res, n_res;

    logic [SLOT_W-1:0] samp_addr;
    logic              samp_oob;
    logic              pid_tag_hit;

    assign samp_addr   = SLOT_W'(r_req.slot_index);
    assign samp_oob    = 32'(r_req.slot_index) >= MAX_ENTRIES;
    assign pid_tag_hit = (i_ram_rdata.pid == r_req.process_id) &&
                         (i_ram_rdata.tag == r_req.container_tag);

    always_comb begin
        n_state        = r_state;
        n_req          = r_req;
        n_scan         = r_scan;
        n_pend         = r_pend;
        n_pend_idx     = r_pend_idx;
        n_valid        = r_valid;
        n_res          = r_res;
        o_ram_wr.we    = 1'b0;
        o_ram_wr.addr  = r_scan;
        o_ram_wr.data  = i_ram_rdata;
        o_ram_raddr    = r_scan;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req               = i_req.payload;
                    n_req.container_tag = tag_form(i_req.payload.container_tag);
                    n_scan              = '0;
                    n_pend              = 1'b0;
                    if (i_req.payload.operation == OP_REGISTER) begin
                        n_state = S_REG;
                    end else if (i_req.payload.operation == OP_UNREGISTER) begin
                        n_state = S_UNREG;
                    end else if (i_req.payload.operation == OP_SAMPLE) begin
                        n_state = S_SAMP_RD;
                    end
                end
            end
            S_REG: begin
                if (r_req.soft_limit > r_req.hard_limit) begin
                    n_res   = '{ST_BAD_LIMITS, 4'd0, ACT_NONE, 22'd0, 48'd0};
                    n_state = S_RESP;
                end else if (!r_valid[r_scan]) begin
                    o_ram_wr.we              = 1'b1;
                    o_ram_wr.data.pid        = r_req.process_id;
                    o_ram_wr.data.tag        = r_req.container_tag;
                    o_ram_wr.data.soft_limit = r_req.soft_limit;
                    o_ram_wr.data.hard_limit = r_req.hard_limit;
                    o_ram_wr.data.warned     = 1'b0;
                    n_valid[r_scan]          = 1'b1;
                    n_res   = '{ST_OK, 4'(r_scan), ACT_NONE, r_req.process_id, 48'd0};
                    n_state = S_RESP;
                end else if (r_scan == LAST_SLOT) begin
                    n_res   = '{ST_FULL, 4'd0, ACT_NONE, 22'd0, 48'd0};
                    n_state = S_RESP;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_UNREG: begin
                // read of slot n overlaps the compare of slot n-1
                if (r_pend && r_valid[r_pend_idx] && pid_tag_hit) begin
                    n_valid[r_pend_idx] = 1'b0;
                    n_res   = '{ST_OK, 4'(r_pend_idx), ACT_NONE, r_req.process_id, 48'd0};
                    n_state = S_RESP;
                end else if (r_pend && r_pend_idx == LAST_SLOT) begin
                    n_res   = '{ST_NOT_FOUND, 4'd0, ACT_NONE, 22'd0, 48'd0};
                    n_state = S_RESP;
                end else begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_scan;
                    n_scan     = r_scan + 1'b1;
                end
            end
            S_SAMP_RD: begin
                o_ram_raddr = samp_addr;
                if (samp_oob || !r_valid[samp_addr]) begin
                    n_res   = '{ST_EMPTY_SLOT, r_req.slot_index, ACT_NONE, 22'd0, 48'd0};
                    n_state = S_RESP;
                end else begin
                    n_state = S_SAMP_EV;
                end
            end
            S_SAMP_EV: begin
                o_ram_wr.addr = samp_addr;
                n_state       = S_RESP;
                if (!r_req.task_exists) begin
                    n_valid[samp_addr] = 1'b0;
                    n_res = '{ST_OK, r_req.slot_index, ACT_STALE, i_ram_rdata.pid, 48'd0};
                end else if (r_req.resident_bytes > i_ram_rdata.hard_limit) begin
                    n_valid[samp_addr] = 1'b0;
                    n_res = '{ST_OK, r_req.slot_index, ACT_KILL, i_ram_rdata.pid,
                              i_ram_rdata.hard_limit};
                end else if (r_req.resident_bytes > i_ram_rdata.soft_limit &&
                             !i_ram_rdata.warned) begin
                    o_ram_wr.we          = 1'b1;
                    o_ram_wr.data.warned = 1'b1;
                    n_res = '{ST_OK, r_req.slot_index, ACT_WARN, i_ram_rdata.pid,
                              i_ram_rdata.soft_limit};
                end else begin
                    n_res = '{ST_OK, r_req.slot_index, ACT_NONE, i_ram_rdata.pid, 48'd0};
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_scan     <= n_scan;
        r_pend_idx <= n_pend_idx;
        r_res      <= n_res;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = r_res;

endmodule

FILE: rtl/core/memory_limit_monitor_table_core.sv
`timescale 1ns / 1ps

// table of up to 16 monitored processes, each with pid, name tag, soft and hard limits
// request channel i_req: register (op 0), unregister (op 1) or sample one slot (op 2)
// response channel o_rsp: exactly one response per request of op 0..2, none for op 3
// both channels are valid/ready; a request is taken on a clock edge with both high
// work from request to response valid:
//   register   one slot valid bit examined per cycle
//   unregister one entry memory read per cycle, compare
//              overlapped with the next read
//   sample     one memory read, then the limit check and write back
// one request in flight at a time; the entry memory single read port sets the scan rate
// a response waits in the output register, so the next request is taken while the
// receiver stalls; with the output register and the sequencer both full, ready drops
// reset (synchronous, active low) empties the table at once: the slot valid bits are
// flops, the entry memory itself is not cleared and only read behind a valid bit
module memory_limit_monitor_table_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mlmt_req_if.sink i_req,
    mlmt_rsp_if.source o_rsp
);
    import mlmt_pkg::*;

    t_rsp              res;
    logic              res_valid;
    logic              res_ready;
    t_ram_wr           ram_wr;
    logic [SLOT_W-1:0] ram_raddr;
    t_entry            ram_rdata;

    // output register between the sequencer and the receiver
    logic r_out_valid;
    t_rsp r_out;

    mlmt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_wr    (ram_wr),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // pid, tag, limits and warned flag of every slot
    mlmt_entry_ram u_entry_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // take a new response whenever the register is empty or being drained
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule

FILE: tb/memory_limit_monitor_table_core_tb.sv
`timescale 1ns / 1ps

module memory_limit_monitor_table_core_tb;
    import mlmt_pkg::*;

    localparam int RANDOM_REQS  = 1700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = MAX_ENTRIES + 8;
    localparam int REPORT_MAX   = 10;

    // the fourth operation code, which the block must swallow without a response
    localparam logic [1:0]  OP_SPARE  = 2'd3;
    localparam logic [47:0] BYTES_MAX = '1;
    localparam logic [21:0] PID_MAX   = '1;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mlmt_req_if req_ch ();
    mlmt_rsp_if rsp_ch ();

    // driven only from the falling edge
    logic tx_valid = 1'b0;
    t_req tx_item  = '0;
    logic rx_ready = 1'b0;

    assign req_ch.valid   = tx_valid;
    assign req_ch.payload = tx_item;
    assign rsp_ch.ready   = rx_ready;

    memory_limit_monitor_table_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // shadow of the slot table, updated as each request is taken
    logic        tbl_valid  [MAX_ENTRIES] = '{default: 1'b0};
    logic [21:0] tbl_pid    [MAX_ENTRIES];
    logic [63:0] tbl_tag    [MAX_ENTRIES];
    logic [47:0] tbl_soft   [MAX_ENTRIES];
    logic [47:0] tbl_hard   [MAX_ENTRIES];
    logic        tbl_warned [MAX_ENTRIES];

    t_req req_backlog [$];   // requests waiting for the driver
    t_rsp due_rsp     [$];   // responses owed by the block, oldest first

    logic req_taken   = 1'b0;
    bit   calm        = 1'b0;   // no idling on either side while set
    int   cycle_count = 0;
    int   fault_count = 0;
    int   status_seen [8];
    int   action_seen [4];

    // small pools so that ids and names repeat across entries
    logic [21:0] pid_pool [8];
    logic [63:0] tag_pool [8];

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // name as the table holds it: bytes up to the first zero byte, the rest cleared
    function automatic logic [63:0] trim_name(input logic [63:0] raw);
        logic [63:0] clean;
        int          n;
        clean = '0;
        n     = 0;
        while (n < NAME_BYTES && raw[8*n +: 8] != 8'h00) begin
            clean[8*n +: 8] = raw[8*n +: 8];
            n++;
        end
        return clean;
    endfunction

    // works out the response to one request and moves the shadow table on
    function automatic bit judge_request(input t_req rq, output t_rsp rs);
        logic [63:0] name;
        int          slot;
        int          idx;
        rs        = '0;
        rs.status = ST_OK;
        rs.action = ACT_NONE;
        name      = trim_name(rq.container_tag);
        slot      = -1;
        idx       = rq.slot_index;
        if (rq.operation == OP_REGISTER) begin
            if (rq.soft_limit > rq.hard_limit) begin
                rs.status = ST_BAD_LIMITS;
            end else begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (slot < 0 && !tbl_valid[i]) slot = i;
                end
                if (slot < 0) begin
                    rs.status = ST_FULL;
                end else begin
                    tbl_valid[slot]  = 1'b1;
                    tbl_pid[slot]    = rq.process_id;
                    tbl_tag[slot]    = name;
                    tbl_soft[slot]   = rq.soft_limit;
                    tbl_hard[slot]   = rq.hard_limit;
                    tbl_warned[slot] = 1'b0;
                    rs.slot_used     = 4'(slot);
                    rs.entry_pid     = rq.process_id;
                end
            end
            return 1'b1;
        end
        if (rq.operation == OP_UNREGISTER) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (slot < 0 && tbl_valid[i] && tbl_pid[i] == rq.process_id
                        && tbl_tag[i] == name) slot = i;
            end
            if (slot < 0) begin
                rs.status = ST_NOT_FOUND;
            end else begin
                tbl_valid[slot] = 1'b0;
                rs.slot_used    = 4'(slot);
                rs.entry_pid    = rq.process_id;
            end
            return 1'b1;
        end
        if (rq.operation == OP_SAMPLE) begin
            rs.slot_used = rq.slot_index;
            if (!tbl_valid[idx]) begin
                rs.status = ST_EMPTY_SLOT;
            end else begin
                rs.entry_pid = tbl_pid[idx];
                if (!rq.task_exists) begin
                    tbl_valid[idx] = 1'b0;
                    rs.action      = ACT_STALE;
                end else if (rq.resident_bytes > tbl_hard[idx]) begin
                    tbl_valid[idx]   = 1'b0;
                    rs.action        = ACT_KILL;
                    rs.limit_crossed = tbl_hard[idx];
                end else if (rq.resident_bytes > tbl_soft[idx] && !tbl_warned[idx]) begin
                    tbl_warned[idx]  = 1'b1;
                    rs.action        = ACT_WARN;
                    rs.limit_crossed = tbl_soft[idx];
                end
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // byte counts near zero, near the top, or anywhere
    function automatic logic [47:0] pick_bytes();
        case ($urandom_range(0, 3))
            0:       return 48'($urandom_range(0, 1023));
            1:       return BYTES_MAX - 48'($urandom_range(0, 1023));
            default: return 48'(rand64());
        endcase
    endfunction

    function automatic logic [47:0] step_up(input logic [47:0] x);
        return (x == BYTES_MAX) ? x : x + 48'd1;
    endfunction

    // random bytes after the first zero byte, which the table must disregard
    function automatic logic [63:0] vary_tail(input logic [63:0] raw);
        logic [63:0] noise;
        int          n;
        noise = rand64();
        n     = 0;
        while (n < 8 && raw[8*n +: 8] != 8'h00) n++;
        for (int k = n + 1; k < 8; k++) raw[8*k +: 8] = noise[8*k +: 8];
        return raw;
    endfunction

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 25);
    endfunction

    // next random request, aimed at entries that the shadow table holds now
    function automatic t_req fresh_request();
        t_req        rq;
        int          pick;
        int          slot;
        int          live [$];
        logic [47:0] lo;
        logic [47:0] hi;
        logic [63:0] span;
        rq.operation      = OP_SPARE;
        rq.process_id     = 22'($urandom);
        rq.container_tag  = rand64();
        rq.soft_limit     = 48'(rand64());
        rq.hard_limit     = 48'(rand64());
        rq.slot_index     = 4'($urandom);
        rq.resident_bytes = 48'(rand64());
        rq.task_exists    = 1'($urandom);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (tbl_valid[i]) live.push_back(i);
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            return rq;
        end
        if (pick < 33) begin
            rq.operation = OP_REGISTER;
            if ($urandom_range(0, 1)) rq.process_id = pid_pool[$urandom_range(0, 7)];
            if ($urandom_range(0, 2) != 0) begin
                rq.container_tag = vary_tail(tag_pool[$urandom_range(0, 7)]);
            end
            lo = pick_bytes();
            hi = pick_bytes();
            if (lo > hi) begin
                span = 64'(lo);
                lo   = hi;
                hi   = 48'(span);
            end
            case ($urandom_range(0, 9))
                0: begin
                    // limits the wrong way round
                    if (lo == hi) begin
                        if (lo == '0) hi = 48'd1;
                        else lo = lo - 48'd1;
                    end
                    rq.soft_limit = hi;
                    rq.hard_limit = lo;
                end
                1: begin
                    rq.soft_limit = hi;
                    rq.hard_limit = hi;
                end
                default: begin
                    rq.soft_limit = lo;
                    rq.hard_limit = hi;
                end
            endcase
            return rq;
        end
        if (pick < 55) begin
            rq.operation = OP_UNREGISTER;
            if (live.size() != 0 && $urandom_range(0, 4) != 0) begin
                slot             = live[$urandom_range(0, live.size() - 1)];
                rq.process_id    = tbl_pid[slot];
                rq.container_tag = vary_tail(tbl_tag[slot]);
            end else begin
                rq.process_id    = pid_pool[$urandom_range(0, 7)];
                rq.container_tag = vary_tail(tag_pool[$urandom_range(0, 7)]);
            end
            return rq;
        end
        rq.operation   = OP_SAMPLE;
        rq.task_exists = ($urandom_range(0, 9) != 0);
        if (live.size() != 0 && $urandom_range(0, 4) != 0) begin
            rq.slot_index = 4'(live[$urandom_range(0, live.size() - 1)]);
        end
        slot = rq.slot_index;
        if (tbl_valid[slot]) begin
            lo = tbl_soft[slot];
            hi = tbl_hard[slot];
            case ($urandom_range(0, 7))
                0: rq.resident_bytes = '0;
                1: rq.resident_bytes = lo;
                2: rq.resident_bytes = step_up(lo);
                3: rq.resident_bytes = hi;
                4: rq.resident_bytes = step_up(hi);
                5: rq.resident_bytes = BYTES_MAX;
                6: begin
                    span = 64'(hi) - 64'(lo) + 64'd1;
                    rq.resident_bytes = 48'(64'(lo) + rand64() % span);
                end
                default: ;
            endcase
        end
        return rq;
    endfunction

    task automatic queue_req(input logic [1:0] op, input logic [21:0] pid,
                             input logic [63:0] tag, input logic [47:0] soft_lim,
                             input logic [47:0] hard, input logic [3:0] idx,
                             input logic [47:0] rss, input logic alive);
        t_req rq;
        rq.operation      = op;
        rq.process_id     = pid;
        rq.container_tag  = tag;
        rq.soft_limit     = soft_lim;
        rq.hard_limit     = hard;
        rq.slot_index     = idx;
        rq.resident_bytes = rss;
        rq.task_exists    = alive;
        req_backlog.push_back(rq);
    endtask

    // holds until every request has gone out and every response has come back
    task automatic wait_quiet();
        while (req_backlog.size() != 0 || tx_valid || due_rsp.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic report_fault(input string what, input t_rsp want, input t_rsp got);
        fault_count++;
        if (fault_count <= REPORT_MAX) begin
            $display("%0t %s: expected status %0d slot %0d action %0d pid %h limit %h",
                     $time, what, want.status, want.slot_used, want.action,
                     want.entry_pid, want.limit_crossed);
            $display("    actual status %0d slot %0d action %0d pid %h limit %h",
                     got.status, got.slot_used, got.action, got.entry_pid,
                     got.limit_crossed);
        end
    endtask

    // request driver: a request stays on the bus until taken, then the next one
    // goes out unless the sender takes a break; the response side stalls at random
    always @(negedge i_clk) begin
        t_req nxt_item;
        logic nxt_valid;
        nxt_item  = tx_item;
        nxt_valid = tx_valid;
        if (i_rst_n) begin
            if (!tx_valid || req_taken) begin
                nxt_valid = 1'b0;
                if (req_backlog.size() != 0 && !take_break()) begin
                    nxt_item  = req_backlog.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            rx_ready <= !take_break();
        end
        tx_item  <= nxt_item;
        tx_valid <= nxt_valid;
    end

    // monitor: checks each response against the oldest one owed, then books
    // the response owed for a request taken at this edge
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("memory_limit_monitor_table_core_tb: errors");
            $finish;
        end else begin
            req_taken <= i_rst_n && req_ch.valid && req_ch.ready;
            if (i_rst_n) begin
                if (rsp_ch.valid && rsp_ch.ready) begin
                    got = rsp_ch.payload;
                    if (due_rsp.size() == 0) begin
                        report_fault("response with nothing owed", '0, got);
                    end else begin
                        want = due_rsp.pop_front();
                        if (got.status !== want.status || got.slot_used !== want.slot_used
                                || got.action !== want.action
                                || got.entry_pid !== want.entry_pid
                                || got.limit_crossed !== want.limit_crossed) begin
                            report_fault("response mismatch", want, got);
                        end else begin
                            status_seen[want.status]++;
                            action_seen[want.action]++;
                        end
                    end
                end
                if (req_ch.valid && req_ch.ready && judge_request(req_ch.payload, want)) begin
                    due_rsp.push_back(want);
                end
            end
        end
    end

    initial begin
        t_req rq;
        int   made;
        made = 0;
        for (int i = 0; i < 8; i++) begin
            pid_pool[i] = 22'($urandom);
            tag_pool[i] = rand64();
            // every other name ends early
            if (i % 2 == 1) tag_pool[i][8*$urandom_range(0, 7) +: 8] = 8'h00;
        end
        tag_pool[0] = '0;
        pid_pool[0] = PID_MAX;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole table first so that no entry is ever looked at unwritten
        queue_req(OP_REGISTER, '0, '0, '0, '0, '0, '0, 1'b0);
        queue_req(OP_REGISTER, PID_MAX, '1, BYTES_MAX, BYTES_MAX, '1, BYTES_MAX, 1'b1);
        // name with a zero byte in the middle
        queue_req(OP_REGISTER, 22'h15555, 64'hFFEE_DDCC_0055_6677, 48'd100, 48'd200,
                  '0, '0, 1'b0);
        queue_req(OP_REGISTER, 22'd3, 64'h0000_0033_636F_7270, 48'd1000, 48'd2000,
                  '0, '0, 1'b1);
        // soft equal to hard
        queue_req(OP_REGISTER, 22'd4, 64'h0000_0000_0000_0034, 48'd5000, 48'd5000,
                  '0, '0, 1'b1);
        for (int i = 5; i < MAX_ENTRIES; i++) begin
            lo_hi_fill: begin
                logic [47:0] soft_lim;
                soft_lim = 48'($urandom_range(0, 9999));
                queue_req(OP_REGISTER, pid_pool[i % 8], vary_tail(tag_pool[i % 8]),
                          soft_lim, soft_lim + 48'($urandom_range(0, 5000)), 4'($urandom),
                          48'(rand64()), 1'($urandom));
            end
        end
        // table full, then bad limits on a full table
        queue_req(OP_REGISTER, 22'd99, 64'h1, 48'd1, 48'd2, '0, '0, 1'b1);
        queue_req(OP_REGISTER, 22'd98, 64'h2, 48'd201, 48'd200, '0, '0, 1'b1);
        // unregister with nothing matching, then one matching only on the trimmed name
        queue_req(OP_UNREGISTER, 22'h2AAAAA, 64'h1, '0, '0, '0, '0, 1'b1);
        queue_req(OP_UNREGISTER, 22'h15555, 64'h1234_5678_0055_6677, '0, '0, '0, '0, 1'b1);
        // sample of the slot just freed
        queue_req(OP_SAMPLE, '0, '0, '0, '0, 4'd2, 48'd500, 1'b1);
        // largest size on the largest limits, then the task has gone
        queue_req(OP_SAMPLE, '0, '0, '0, '0, 4'd1, BYTES_MAX, 1'b1);
        queue_req(OP_SAMPLE, '0, '0, '0, '0, 4'd1, '0, 1'b0);
        // warning, no second warning, then kill over the hard limit
        queue_req(OP_SAMPLE, '0, '0, '0, '0, 4'd3, 48'd1001, 1'b1);
        queue_req(OP_SAMPLE, '0, '0, '0, '0, 4'd3, 48'd2000, 1'b1);
        queue_req(OP_SAMPLE, '0, '0, '0, '0, 4'd3, 48'd2001, 1'b1);
        // soft equal to hard: one byte over kills straight away
        queue_req(OP_SAMPLE, '0, '0, '0, '0, 4'd4, 48'd5001, 1'b1);
        // spare operation code must leave no trace
        queue_req(OP_SPARE, PID_MAX, '1, BYTES_MAX, '0, '1, BYTES_MAX, 1'b1);
        wait_quiet();

        while (made < RANDOM_REQS) begin
            while (req_backlog.size() != 0) @(posedge i_clk);
            // sender holds off until the block has answered everything
            if (made == 500 || made == 1300) wait_quiet();
            calm = (made >= 700 && made < 1000);
            rq   = fresh_request();
            req_backlog.push_back(rq);
            if (rq.operation != OP_SPARE) made++;
        end
        calm = 1'b0;

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("table run: %0d ok, %0d bad limits, %0d full, %0d not found, %0d empty slot",
                 status_seen[ST_OK], status_seen[ST_BAD_LIMITS], status_seen[ST_FULL],
                 status_seen[ST_NOT_FOUND], status_seen[ST_EMPTY_SLOT]);
        $display("sample actions: %0d warnings, %0d kills, %0d stale; %0d faults",
                 action_seen[ACT_WARN], action_seen[ACT_KILL], action_seen[ACT_STALE],
                 fault_count);
        if (fault_count == 0) begin
            $display("memory_limit_monitor_table_core_tb: clean");
        end else begin
            $display("memory_limit_monitor_table_core_tb: errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mlmt_pkg.sv
rtl/core/mlmt_if.sv
rtl/core/mlmt_entry_ram.sv
rtl/core/mlmt_seq.sv
rtl/core/memory_limit_monitor_table_core.sv
tb/memory_limit_monitor_table_core_tb.sv
